>>> hw/rtl/ips_pkg.sv
// ----------------------------------------------------------------------------
// ips_pkg: shared types for the interleaved parity sorter
// Word type and the command and status groups between controller and datapath.
// ----------------------------------------------------------------------------
package ips_pkg;

    localparam int VW = 32;

    typedef logic signed [VW-1:0] t_word;

    typedef struct packed {
        logic load;
        logic drop;
        logic advance;
        logic clear;
    } t_cmd;

    typedef struct packed {
        logic full;
        logic last_pos;
    } t_sts;

endpackage

>>> hw/rtl/ips_if.sv
// ----------------------------------------------------------------------------
// ips_if: word channels of the interleaved parity sorter
// Valid/ready channels for input words and result words.
// ----------------------------------------------------------------------------
interface ips_in_if;
    logic                valid;
    logic                ready;
    logic signed [31:0]  value_in;
    logic                is_last;

    modport source (output valid, output value_in, output is_last, input ready);
    modport sink   (input valid, input value_in, input is_last, output ready);
endinterface

interface ips_out_if;
    logic                valid;
    logic                ready;
    logic signed [31:0]  value_out;
    logic                last_out;
    logic                overflow;

    modport source (output valid, output value_out, output last_out, output overflow,
                    input ready);
    modport sink   (input valid, input value_out, input last_out, input overflow,
                    output ready);
endinterface

>>> hw/rtl/interleaved_parity_sorter_top.sv
// ----------------------------------------------------------------------------
// interleaved_parity_sorter_top: sort even and odd positions separately
// Loads a list, keeps each parity group sorted, then emits it in position order.
// ----------------------------------------------------------------------------
// Load: one input word per cycle; each word is inserted into its chain as it is accepted.
// Emit: first result the cycle after the last input word, then one per stored word.
// Input is held off while a list is emitted.
// Synchronous active-low reset empties the list and clears overflow; no clearing pass.
module interleaved_parity_sorter_top #(
    parameter int MAX_ITEMS = 64
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    ips_in_if.sink    i_in,
    ips_out_if.source o_out
);
    import ips_pkg::*;

    t_cmd cmd;
    t_sts sts;

    ips_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .i_is_last   (i_in.is_last),
        .i_out_ready (o_out.ready),
        .i_sts       (sts),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .o_cmd       (cmd)
    );

    ips_dp #(.MAX_ITEMS(MAX_ITEMS)) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .i_value    (i_in.value_in),
        .o_sts      (sts),
        .o_value    (o_out.value_out),
        .o_last     (o_out.last_out),
        .o_overflow (o_out.overflow)
    );

endmodule

>>> hw/rtl/ips_chain.sv
// ----------------------------------------------------------------------------
// ips_chain: sorted insertion chain
// Row of cells kept in ascending signed order; inserts one word per cycle and
// shifts toward the head to stream the sorted words out.
// ----------------------------------------------------------------------------
module ips_chain #(
    parameter int DEPTH = 32,
    parameter int FW    = 7
) (
    input  logic           i_clk,
    input  logic           i_ins,
    input  logic           i_shf,
    input  logic [FW-1:0]  i_fill,
    input  ips_pkg::t_word i_value,
    output ips_pkg::t_word o_head
);
    import ips_pkg::*;

    t_word            r_cell [DEPTH];
    t_word            n_cell [DEPTH];
    logic [DEPTH-1:0] lt;

    for (genvar k = 0; k < DEPTH; k++) begin : g_cell
        assign lt[k] = (FW'(k) >= i_fill) || (i_value < r_cell[k]);

        always_comb begin
            n_cell[k] = r_cell[k];
            if (i_ins && lt[k]) begin
                n_cell[k] = i_value;
                if (k > 0) begin
                    if (lt[(k > 0) ? k - 1 : 0]) begin
                        n_cell[k] = r_cell[(k > 0) ? k - 1 : 0];
                    end
                end
            end else if (i_shf) begin
                n_cell[k] = r_cell[(k < DEPTH - 1) ? k + 1 : k];
            end
        end

        always_ff @(posedge i_clk) begin
            r_cell[k] <= n_cell[k];
        end
    end

    assign o_head = r_cell[0];

endmodule

>>> hw/rtl/ips_dp.sv
// ----------------------------------------------------------------------------
// ips_dp: datapath of the interleaved parity sorter
// Even and odd insertion chains, element count, emit position and overflow.
// ----------------------------------------------------------------------------
module ips_dp #(
    parameter int MAX_ITEMS = 64
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  ips_pkg::t_cmd  i_cmd,
    input  ips_pkg::t_word i_value,
    output ips_pkg::t_sts  o_sts,
    output ips_pkg::t_word o_value,
    output logic           o_last,
    output logic           o_overflow
);
    import ips_pkg::*;

    localparam int CW         = $clog2(MAX_ITEMS + 1);
    localparam int EVEN_DEPTH = (MAX_ITEMS + 1) / 2;
    localparam int ODD_DEPTH  = MAX_ITEMS / 2;

    logic [CW-1:0] r_count;
    logic [CW-1:0] r_pos;
    logic          r_ovf;
    logic [CW-1:0] half;
    t_word         even_head;
    t_word         odd_head;
    logic          ins_even;
    logic          ins_odd;
    logic          shf_even;
    logic          shf_odd;

    assign half     = {1'b0, r_count[CW-1:1]};
    assign ins_even = i_cmd.load && !r_count[0];
    assign ins_odd  = i_cmd.load &&  r_count[0];
    assign shf_even = i_cmd.advance && !r_pos[0];
    assign shf_odd  = i_cmd.advance &&  r_pos[0];

    ips_chain #(.DEPTH(EVEN_DEPTH), .FW(CW)) u_even (
        .i_clk   (i_clk),
        .i_ins   (ins_even),
        .i_shf   (shf_even),
        .i_fill  (half),
        .i_value (i_value),
        .o_head  (even_head)
    );

    ips_chain #(.DEPTH(ODD_DEPTH), .FW(CW)) u_odd (
        .i_clk   (i_clk),
        .i_ins   (ins_odd),
        .i_shf   (shf_odd),
        .i_fill  (half),
        .i_value (i_value),
        .o_head  (odd_head)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_pos   <= '0;
            r_ovf   <= 1'b0;
        end else if (i_cmd.clear) begin
            r_count <= '0;
            r_pos   <= '0;
            r_ovf   <= 1'b0;
        end else begin
            if (i_cmd.load) begin
                r_count <= r_count + CW'(1);
            end
            if (i_cmd.drop) begin
                r_ovf <= 1'b1;
            end
            if (i_cmd.advance) begin
                r_pos <= r_pos + CW'(1);
            end
        end
    end

    assign o_sts.full     = (r_count == CW'(MAX_ITEMS));
    assign o_sts.last_pos = (CW'(r_pos + CW'(1)) == r_count);
    assign o_value        = r_pos[0] ? odd_head : even_head;
    assign o_last         = o_sts.last_pos;
    assign o_overflow     = r_ovf;

endmodule

>>> hw/rtl/ips_ctrl.sv
// ----------------------------------------------------------------------------
// ips_ctrl: controller of the interleaved parity sorter
// Alternates between loading a list and emitting it; issues datapath commands.
// ----------------------------------------------------------------------------
module ips_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  logic          i_is_last,
    input  logic          i_out_ready,
    input  ips_pkg::t_sts i_sts,
    output logic          o_in_ready,
    output logic          o_out_valid,
    output ips_pkg::t_cmd o_cmd
);
    import ips_pkg::*;

    typedef enum logic {
        ST_LOAD,
        ST_EMIT
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   in_fire;
    logic   out_fire;

    assign o_in_ready  = (r_state == ST_LOAD);
    assign o_out_valid = (r_state == ST_EMIT);
    assign in_fire     = i_in_valid && o_in_ready;
    assign out_fire    = o_out_valid && i_out_ready;

    always_comb begin
        n_state       = r_state;
        o_cmd.load    = in_fire && !i_sts.full;
        o_cmd.drop    = in_fire &&  i_sts.full;
        o_cmd.advance = out_fire;
        o_cmd.clear   = out_fire && i_sts.last_pos;
        case (r_state)
            ST_LOAD: begin
                if (in_fire && i_is_last) begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (out_fire && i_sts.last_pos) begin
                    n_state = ST_LOAD;
                end
            end
            default: n_state = ST_LOAD;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_LOAD;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

>>> hw/rtl/ips_check.sv
// ----------------------------------------------------------------------------
// ips_check: port-level checks for the interleaved parity sorter
// Load and emit phases alternate cleanly around list boundaries; overflow holds while emitting.
// ----------------------------------------------------------------------------
module ips_check (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_in_valid,
    input logic i_in_ready,
    input logic i_is_last,
    input logic i_out_valid,
    input logic i_out_ready,
    input logic i_last_out,
    input logic i_overflow
);

    a_phase_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_in_ready && i_out_valid))
        else $error("input ready while emitting");

    a_emit_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready && i_is_last) |=> i_out_valid)
        else $error("no emission after last input word");

    a_emit_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_out_ready && i_last_out) |=> (i_in_ready && !i_out_valid))
        else $error("no return to load after last result");

    a_ovf_steady: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && $past(i_out_valid)) |-> $stable(i_overflow))
        else $error("overflow changed within a list");

    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> (i_in_ready && !i_out_valid))
        else $error("not loading after reset");

endmodule

bind interleaved_parity_sorter_top ips_check u_ips_check (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_is_last   (i_in.is_last),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_last_out  (o_out.last_out),
    .i_overflow  (o_out.overflow)
);
